// File: rtl/gcd_pkg.sv
package gcd_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 31;
    localparam int NLANE        = 4;
    // pipeline depth in registers, input to output word
    localparam int NSTG         = 43 + 2 * CORDIC_STEPS;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DIST_W = 26;
    localparam int RAD_W  = 24;

    typedef logic signed [33:0] t_cq;
    typedef logic [61:0]        t_sq;
    typedef logic [30:0]        t_uq;

    localparam logic signed [LAT_W-1:0] LAT_LIM = 28'sd90000000;
    localparam logic signed [LON_W-1:0] LON_LIM = 29'sd180000000;
    localparam logic [29:0]  LON_TURN  = 30'd360000000;
    localparam logic [29:0]  LON_HALF  = 30'd180000000;

    localparam t_cq  Q30_ONE   = 34'sd1073741824;
    localparam t_cq  HALF_PI   = 34'sd1686629713;
    localparam t_cq  GAIN      = 34'sd652032874;
    localparam t_uq  ONE_U     = 31'd1073741824;

    // pi/360e6 * 2^62 split into two 18-bit halves
    localparam logic [17:0] K_HI = 18'd153520;
    localparam logic [17:0] K_LO = 18'd205664;

    localparam logic [RAD_W-1:0] RADIUS_RST = 24'd6371000;

    // register index decode (paddr[2])
    localparam logic REG_RADIUS = 1'b0;

    localparam t_cq ATAN_HEAD [11] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575
    };

    function automatic t_cq atan_q30(input int i);
        t_cq v;
        if (i < 11) begin
            v = ATAN_HEAD[i];
        end else if (i <= 30) begin
            v = (34'sd1 <<< (30 - i)) - 34'sd1;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    // q30 product rounding, product at most 2^60
    function automatic t_uq rnd30(input t_sq p);
        t_sq s;
        s = p + 62'd536870912;
        return s[60:30];
    endfunction

endpackage

// File: rtl/gcd_in_if.sv
interface gcd_in_if import gcd_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_lat;
    logic signed [LON_W-1:0] first_lon;
    logic signed [LAT_W-1:0] second_lat;
    logic signed [LON_W-1:0] second_lon;

    modport source (output valid, first_lat, first_lon, second_lat, second_lon,
                    input ready);
    modport sink   (input valid, first_lat, first_lon, second_lat, second_lon,
                    output ready);
endinterface

// File: rtl/gcd_out_if.sv
interface gcd_out_if import gcd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

// File: rtl/great_circle_distance.sv
// channel   dir  handshake      word
// i_pts     in   valid/ready    first_lat, first_lon, second_lat, second_lon
// o_dist    out  valid/ready    distance_m
// apb       in   psel/penable   sphere_radius_m at byte 0
//
// fully pipelined: one word per cycle unless the output stalls; the depth comes
// from two unrolled cordic chains and a 31-stage sqrt
// the whole pipe advances together; it holds only when the output register
// is full and not taken, and then no new word enters, even with bubbles inside
// synchronous active-low reset clears valid bits and loads the radius register with 6371000
module great_circle_distance import gcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcd_in_if.sink      i_pts,
    gcd_out_if.source   o_dist,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic en;
    logic [NSTG-1:0] r_vld;
    logic [RAD_W-1:0] r_radius;

    // global advance: output register empty or being taken
    assign en = !r_vld[NSTG-1] || o_dist.ready;
    assign i_pts.ready = en;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? {8'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
            r_radius <= pwdata[RAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pts.valid};
        end
    end

    // ---------------- stage 1: clamp coordinates ----------------
    logic signed [LAT_W-1:0] r_lat1, r_lat2;
    logic signed [LON_W-1:0] r_lon1, r_lon2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat1 <= (i_pts.first_lat > LAT_LIM) ? LAT_LIM :
                      (i_pts.first_lat < -LAT_LIM) ? -LAT_LIM : i_pts.first_lat;
            r_lat2 <= (i_pts.second_lat > LAT_LIM) ? LAT_LIM :
                      (i_pts.second_lat < -LAT_LIM) ? -LAT_LIM : i_pts.second_lat;
            r_lon1 <= (i_pts.first_lon > LON_LIM) ? LON_LIM :
                      (i_pts.first_lon < -LON_LIM) ? -LON_LIM : i_pts.first_lon;
            r_lon2 <= (i_pts.second_lon > LON_LIM) ? LON_LIM :
                      (i_pts.second_lon < -LON_LIM) ? -LON_LIM : i_pts.second_lon;
        end
    end

    // ---------------- stage 2: differences, half-microdegree angles ----------
    // lanes: 0 cos lat1, 1 cos lat2, 2 sin dlat/2, 3 sin dlon/2
    logic signed [28:0] dlat;
    logic signed [29:0] dlon;
    logic [28:0] adlat;
    logic [29:0] adlon, fdlon;
    logic [LAT_W-1:0] alat1, alat2;
    logic [27:0] n_u [NLANE];
    logic [27:0] r_u [NLANE];

    always_comb begin
        dlat  = {r_lat2[LAT_W-1], r_lat2} - {r_lat1[LAT_W-1], r_lat1};
        dlon  = {r_lon2[LON_W-1], r_lon2} - {r_lon1[LON_W-1], r_lon1};
        adlat = dlat[28] ? 29'(-dlat) : 29'(dlat);
        adlon = dlon[29] ? 30'(-dlon) : 30'(dlon);
        // past half a turn the other way round is shorter, same sine squared
        fdlon = (adlon > LON_HALF) ? LON_TURN - adlon : adlon;
        alat1 = r_lat1[LAT_W-1] ? LAT_W'(-r_lat1) : LAT_W'(r_lat1);
        alat2 = r_lat2[LAT_W-1] ? LAT_W'(-r_lat2) : LAT_W'(r_lat2);
        n_u[0] = {alat1[26:0], 1'b0};
        n_u[1] = {alat2[26:0], 1'b0};
        n_u[2] = adlat[27:0];
        n_u[3] = fdlon[27:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u <= n_u;
        end
    end

    // ---------------- stage 3: partial products to radians ----------------
    logic [45:0] r_ph [NLANE];
    logic [45:0] r_pl [NLANE];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NLANE; l++) begin
                r_ph[l] <= 46'(r_u[l] * K_HI);
                r_pl[l] <= 46'(r_u[l] * K_LO);
            end
        end
    end

    // ---------------- stage 4 + rotation cordic ----------------
    // index 0 holds the start vector, index k+1 the result of step k
    t_cq r_rx [CORDIC_STEPS+1][NLANE];
    t_cq r_ry [CORDIC_STEPS+1][NLANE];
    t_cq r_rz [CORDIC_STEPS+1][NLANE];
    t_cq n_rx [CORDIC_STEPS+1][NLANE];
    t_cq n_ry [CORDIC_STEPS+1][NLANE];
    t_cq n_rz [CORDIC_STEPS+1][NLANE];
    logic [63:0] rsum [NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            rsum[l] = ({18'd0, r_ph[l]} << 18) + {18'd0, r_pl[l]} + 64'h8000_0000;
            n_rx[0][l] = GAIN;
            n_ry[0][l] = '0;
            n_rz[0][l] = {2'b00, rsum[l][63:32]};
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            for (int l = 0; l < NLANE; l++) begin
                if (r_rz[k][l] >= 0) begin
                    n_rx[k+1][l] = r_rx[k][l] - (r_ry[k][l] >>> k);
                    n_ry[k+1][l] = r_ry[k][l] + (r_rx[k][l] >>> k);
                    n_rz[k+1][l] = r_rz[k][l] - atan_q30(k);
                end else begin
                    n_rx[k+1][l] = r_rx[k][l] + (r_ry[k][l] >>> k);
                    n_ry[k+1][l] = r_ry[k][l] - (r_rx[k][l] >>> k);
                    n_rz[k+1][l] = r_rz[k][l] + atan_q30(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rz <= n_rz;
        end
    end

    // ---------------- haversine term ----------------
    t_uq n_m [NLANE];
    t_uq r_m [NLANE];
    t_cq cx0, cx1, sy2, sy3;

    always_comb begin
        cx0 = r_rx[CORDIC_STEPS][0];
        cx1 = r_rx[CORDIC_STEPS][1];
        sy2 = r_ry[CORDIC_STEPS][2];
        sy3 = r_ry[CORDIC_STEPS][3];
        // cosines clamped to [0, 1], sines to [-1, 1] then folded positive
        n_m[0] = (cx0 < 0) ? '0 : (cx0 > Q30_ONE) ? ONE_U : cx0[30:0];
        n_m[1] = (cx1 < 0) ? '0 : (cx1 > Q30_ONE) ? ONE_U : cx1[30:0];
        n_m[2] = (sy2 > Q30_ONE || sy2 < -Q30_ONE) ? ONE_U :
                 (sy2 < 0) ? 31'(-sy2) : sy2[30:0];
        n_m[3] = (sy3 > Q30_ONE || sy3 < -Q30_ONE) ? ONE_U :
                 (sy3 < 0) ? 31'(-sy3) : sy3[30:0];
    end

    t_sq r_p_cc, r_p_sd, r_p_so, r_p_a;
    t_uq r_cc, r_sd, r_so, r_sd_d;
    logic [31:0] asum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m    <= n_m;
            r_p_cc <= 62'(r_m[0] * r_m[1]);
            r_p_sd <= 62'(r_m[2] * r_m[2]);
            r_p_so <= 62'(r_m[3] * r_m[3]);
            r_cc   <= rnd30(r_p_cc);
            r_sd   <= rnd30(r_p_sd);
            r_so   <= rnd30(r_p_so);
            r_p_a  <= 62'(r_cc * r_so);
            r_sd_d <= r_sd;
        end
    end

    assign asum = {1'b0, r_sd_d} + {1'b0, rnd30(r_p_a)};

    // ---------------- square roots of a and 1-a ----------------
    t_sq r_sny [SQRT_STEPS+1];
    t_sq r_sry [SQRT_STEPS+1];
    t_sq r_snx [SQRT_STEPS+1];
    t_sq r_srx [SQRT_STEPS+1];
    t_sq n_sny [SQRT_STEPS+1];
    t_sq n_sry [SQRT_STEPS+1];
    t_sq n_snx [SQRT_STEPS+1];
    t_sq n_srx [SQRT_STEPS+1];
    t_uq a_c;
    t_sq bitv, ty, tx;

    always_comb begin
        a_c = (asum > {1'b0, ONE_U}) ? ONE_U : asum[30:0];
        n_sny[0] = {1'b0, a_c, 30'd0};
        n_snx[0] = {1'b0, ONE_U - a_c, 30'd0};
        n_sry[0] = '0;
        n_srx[0] = '0;
        bitv = '0;
        ty = '0;
        tx = '0;
        // one result bit per stage, restoring form
        for (int j = 0; j < SQRT_STEPS; j++) begin
            bitv = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
            ty = r_sry[j] + bitv;
            tx = r_srx[j] + bitv;
            if (r_sny[j] >= ty) begin
                n_sny[j+1] = r_sny[j] - ty;
                n_sry[j+1] = (r_sry[j] >> 1) + bitv;
            end else begin
                n_sny[j+1] = r_sny[j];
                n_sry[j+1] = r_sry[j] >> 1;
            end
            if (r_snx[j] >= tx) begin
                n_snx[j+1] = r_snx[j] - tx;
                n_srx[j+1] = (r_srx[j] >> 1) + bitv;
            end else begin
                n_snx[j+1] = r_snx[j];
                n_srx[j+1] = r_srx[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sny <= n_sny;
            r_sry <= n_sry;
            r_snx <= n_snx;
            r_srx <= n_srx;
        end
    end

    // ---------------- vectoring cordic: atan2(sqrt a, sqrt(1-a)) ----------
    t_cq r_ax [CORDIC_STEPS+1];
    t_cq r_ay [CORDIC_STEPS+1];
    t_cq r_az [CORDIC_STEPS+1];
    t_cq n_ax [CORDIC_STEPS+1];
    t_cq n_ay [CORDIC_STEPS+1];
    t_cq n_az [CORDIC_STEPS+1];
    t_sq ys, xs;

    always_comb begin
        // round to nearest on the leftover remainder
        ys = (r_sny[SQRT_STEPS] > r_sry[SQRT_STEPS]) ?
             r_sry[SQRT_STEPS] + 62'd1 : r_sry[SQRT_STEPS];
        xs = (r_snx[SQRT_STEPS] > r_srx[SQRT_STEPS]) ?
             r_srx[SQRT_STEPS] + 62'd1 : r_srx[SQRT_STEPS];
        n_ay[0] = {3'b000, ys[30:0]};
        n_ax[0] = {3'b000, xs[30:0]};
        n_az[0] = '0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (r_ay[k] >= 0) begin
                n_ax[k+1] = r_ax[k] + (r_ay[k] >>> k);
                n_ay[k+1] = r_ay[k] - (r_ax[k] >>> k);
                n_az[k+1] = r_az[k] + atan_q30(k);
            end else begin
                n_ax[k+1] = r_ax[k] - (r_ay[k] >>> k);
                n_ay[k+1] = r_ay[k] + (r_ax[k] >>> k);
                n_az[k+1] = r_az[k] - atan_q30(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_az <= n_az;
        end
    end

    // ---------------- scale by diameter, round to meters ----------------
    t_cq zq;
    t_uq zc;
    logic [55:0] r_prod;
    logic [55:0] psum;
    logic [DIST_W-1:0] r_dist;

    always_comb begin
        zq = r_az[CORDIC_STEPS];
        zc = (zq < 0) ? '0 : (zq > HALF_PI) ? HALF_PI[30:0] : zq[30:0];
        psum = r_prod + 56'd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 56'({r_radius, 1'b0} * zc);
            r_dist <= psum[55:30];
        end
    end

    assign o_dist.valid      = r_vld[NSTG-1];
    assign o_dist.distance_m = r_dist;

    // ---------------- checks ----------------
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pts.valid && i_pts.ready) |=> r_vld[0])
        else $error("accepted word did not enter the pipe");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dist.valid && !o_dist.ready) |-> !i_pts.ready)
        else $error("input taken while pipe is stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist.valid |-> (o_dist.distance_m <= 26'd52707178))
        else $error("distance beyond half circumference of largest sphere");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

endmodule
